// File: sv/pbe_pkg.sv
// Shared types, widths and register codes for the particle billboard expander.
package pbe_pkg;

  // Per-particle entries held between the front pipeline and the corner emitter.
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned POS_W  = 32;  // Q16.16 positions
  localparam int unsigned PUSH_W = 49;  // push component, Q.36 (axis*size*spin, summed)
  localparam int unsigned ACC_W  = 53;  // center*2^20 +- A +- B

  localparam logic [15:0] LIFE_ONE = 16'd32768;

  // Register indexes (paddr[5:3])
  typedef enum logic [2:0] {
    REG_RIGHT_AXIS  = 3'd0,
    REG_UP_AXIS     = 3'd1,
    REG_START_SIZE  = 3'd2,
    REG_END_SIZE    = 3'd3,
    REG_START_COLOR = 3'd4,
    REG_END_COLOR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [47:0] right_axis;
    logic [47:0] up_axis;
    logic [15:0] start_size;
    logic [15:0] end_size;
    logic [31:0] start_color;
    logic [31:0] end_color;
  } cfg_t;

  // Input transaction, center_x in the low bits
  typedef struct packed {
    logic signed [15:0] spin_by;
    logic signed [15:0] spin_bx;
    logic signed [15:0] spin_ay;
    logic signed [15:0] spin_ax;
    logic        [15:0] life;
    logic signed [31:0] center_z;
    logic signed [31:0] center_y;
    logic signed [31:0] center_x;
  } particle_t;

  // One queued particle: everything the corner emitter needs
  typedef struct packed {
    logic signed [POS_W-1:0]  center_x;
    logic signed [POS_W-1:0]  center_y;
    logic signed [POS_W-1:0]  center_z;
    logic        [31:0]       color;
    logic signed [PUSH_W-1:0] pa_x;
    logic signed [PUSH_W-1:0] pa_y;
    logic signed [PUSH_W-1:0] pa_z;
    logic signed [PUSH_W-1:0] pb_x;
    logic signed [PUSH_W-1:0] pb_y;
    logic signed [PUSH_W-1:0] pb_z;
  } qent_t;

  // Output transaction, tex_u in the low bit
  typedef struct packed {
    logic signed [31:0] vert_z;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_x;
    logic        [7:0]  alpha_level;
    logic        [7:0]  blue;
    logic        [7:0]  green;
    logic        [7:0]  red;
    logic               tex_v;
    logic               tex_u;
  } corner_t;

endpackage

// File: sv/particle_billboard_expand.sv
// Top level of the particle billboard expander: config registers and channel wiring.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ----------------------------------------
//  in_      slave      in_tvalid / in_tready     in_tdata: one particle
//  out_     master     out_tvalid / out_tready   out_tdata + out_tlast: one quad corner
//  cfg      APB slave  psel/penable/pwrite       paddr/pwdata/prdata, pready tied high
//
// Cycles: each particle yields four corner transactions, one per cycle while
// out_tready is high; the corner emitter's single output register sets that rate.
// An accepted particle passes through the four front stages and the queue write
// before its first corner is loaded into the output register.
// Reset: synchronous, active low; config registers return to their defaults
// and the pipe, queue and output register empty. No clearing pass is needed.
// Stalls: the front keeps accepting while corners wait at the output, up to
// QUEUE_DEPTH particles reserved between the front and the emitter; a stalled
// out_tready holds the output register and backs up through the queue.
module particle_billboard_expand #(
  parameter int unsigned QUEUE_DEPTH = pbe_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,

  // center_x[31:0], center_y[63:32], center_z[95:64], life[111:96],
  // spin_ax[127:112], spin_ay[143:128], spin_bx[159:144], spin_by[175:160]
  input  logic [175:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,

  // tex_u[0], tex_v[1], red[9:2], green[17:10], blue[25:18], alpha_level[33:26],
  // vert_x[65:34], vert_y[97:66], vert_z[129:98], zero[135:130]
  output logic [135:0] out_tdata,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,

  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  pbe_pkg::cfg_t     cfg_r;
  pbe_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  logic             q_push, q_pop, head_valid;
  pbe_pkg::qent_t   q_data, head_data;
  pbe_pkg::corner_t out_corner;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = pbe_pkg::reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.right_axis  <= 48'h0000_0000_4000;
      cfg_r.up_axis     <= 48'h0000_4000_0000;
      cfg_r.start_size  <= 16'h0100;
      cfg_r.end_size    <= 16'h0100;
      cfg_r.start_color <= 32'hffff_ffff;
      cfg_r.end_color   <= 32'h0000_0000;
    end else if (cfg_wr) begin
      // indexes past the list fall through and are ignored
      unique case (reg_idx)
        pbe_pkg::REG_RIGHT_AXIS:  cfg_r.right_axis  <= pwdata[47:0];
        pbe_pkg::REG_UP_AXIS:     cfg_r.up_axis     <= pwdata[47:0];
        pbe_pkg::REG_START_SIZE:  cfg_r.start_size  <= pwdata[15:0];
        pbe_pkg::REG_END_SIZE:    cfg_r.end_size    <= pwdata[15:0];
        pbe_pkg::REG_START_COLOR: cfg_r.start_color <= pwdata[31:0];
        pbe_pkg::REG_END_COLOR:   cfg_r.end_color   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pbe_pkg::REG_RIGHT_AXIS:  prdata = {16'd0, cfg_r.right_axis};
      pbe_pkg::REG_UP_AXIS:     prdata = {16'd0, cfg_r.up_axis};
      pbe_pkg::REG_START_SIZE:  prdata = {48'd0, cfg_r.start_size};
      pbe_pkg::REG_END_SIZE:    prdata = {48'd0, cfg_r.end_size};
      pbe_pkg::REG_START_COLOR: prdata = {32'd0, cfg_r.start_color};
      pbe_pkg::REG_END_COLOR:   prdata = {32'd0, cfg_r.end_color};
      default:                  prdata = '0;
    endcase
  end

  // ---------------- front: accept, interpolate, build push vectors ----------------
  pbe_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_part  (pbe_pkg::particle_t'(in_tdata)),
    .cfg      (cfg_r),
    .q_pop    (q_pop),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  // ---------------- queue between front and back ----------------
  pbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // ---------------- back: four corners per particle ----------------
  pbe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_corner (out_corner),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'd0, out_corner};

endmodule

// File: sv/pbe_front.sv
// Front pipeline: accepts particles, interpolates size/color, builds push vectors.
module pbe_front #(
  parameter int unsigned DEPTH = pbe_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbe_pkg::particle_t in_part,
  input  pbe_pkg::cfg_t      cfg,
  input  logic              q_pop,
  output logic              q_push,
  output pbe_pkg::qent_t     q_data
);

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned PUSH_W = pbe_pkg::PUSH_W;

  // entries reserved: in flight in the pipe plus held in the queue
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1: interpolation products
  logic signed [33:0] s1_size_prod_r;
  logic signed [25:0] s1_col_prod_r [4];
  pbe_pkg::particle_t s1_part_r;

  // stage 2: size and color
  logic        [15:0] s2_size_r;
  logic        [31:0] s2_color_r;
  pbe_pkg::particle_t s2_part_r;

  // stage 3: scaled axes
  logic signed [31:0] s3_r_r [3];
  logic signed [31:0] s3_u_r [3];
  logic        [31:0] s3_color_r;
  pbe_pkg::particle_t s3_part_r;

  // stage 4: push vectors
  pbe_pkg::qent_t s4_ent_r;

  logic        [15:0] life_c;
  logic signed [16:0] size_diff;
  logic signed [16:0] life_s;
  logic signed [33:0] size_prod;
  logic signed [25:0] col_prod [4];
  logic        [15:0] size_val;
  logic        [31:0] color_val;
  logic signed [33:0] size_rnd;
  logic signed [25:0] col_rnd [4];
  logic signed [32:0] r_prod [3];
  logic signed [32:0] u_prod [3];
  logic signed [PUSH_W-1:0] pa [3];
  logic signed [PUSH_W-1:0] pb [3];

  assign in_ready = (cnt_r < CNT_W'(DEPTH));
  assign accept   = in_valid && in_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({accept, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // stage 1 math
  always_comb begin
    life_c    = (in_part.life > pbe_pkg::LIFE_ONE) ? pbe_pkg::LIFE_ONE : in_part.life;
    life_s    = $signed({1'b0, life_c});
    size_diff = $signed({1'b0, cfg.start_size}) - $signed({1'b0, cfg.end_size});
    size_prod = size_diff * life_s;
    for (int c = 0; c < 4; c++) begin
      col_prod[c] = ($signed({1'b0, cfg.start_color[8*c +: 8]})
                   - $signed({1'b0, cfg.end_color[8*c +: 8]})) * life_s;
    end
  end

  // stage 2 math: end + floor((prod + half) / 2^15), wraps back into range
  always_comb begin
    size_rnd = s1_size_prod_r + 34'sd16384;
    size_val = cfg.end_size + size_rnd[30:15];
    for (int c = 0; c < 4; c++) begin
      col_rnd[c]          = s1_col_prod_r[c] + 26'sd16384;
      color_val[8*c +: 8] = cfg.end_color[8*c +: 8] + col_rnd[c][22:15];
    end
  end

  // stage 3 math
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r_prod[c] = $signed(cfg.right_axis[16*c +: 16]) * $signed({1'b0, s2_size_r});
      u_prod[c] = $signed(cfg.up_axis[16*c +: 16]) * $signed({1'b0, s2_size_r});
    end
  end

  // stage 4 math: axis terms widened first so the 32x16 products keep every bit
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pa[c] = PUSH_W'(s3_r_r[c]) * s3_part_r.spin_ax + PUSH_W'(s3_u_r[c]) * s3_part_r.spin_ay;
      pb[c] = PUSH_W'(s3_r_r[c]) * s3_part_r.spin_bx + PUSH_W'(s3_u_r[c]) * s3_part_r.spin_by;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      v1_r  <= accept;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_size_prod_r <= size_prod;
    s1_col_prod_r  <= col_prod;
    s1_part_r      <= in_part;

    s2_size_r  <= size_val;
    s2_color_r <= color_val;
    s2_part_r  <= s1_part_r;

    for (int c = 0; c < 3; c++) begin
      s3_r_r[c] <= r_prod[c][31:0];
      s3_u_r[c] <= u_prod[c][31:0];
    end
    s3_color_r <= s2_color_r;
    s3_part_r  <= s2_part_r;

    s4_ent_r.center_x <= s3_part_r.center_x;
    s4_ent_r.center_y <= s3_part_r.center_y;
    s4_ent_r.center_z <= s3_part_r.center_z;
    s4_ent_r.color    <= s3_color_r;
    s4_ent_r.pa_x     <= pa[0];
    s4_ent_r.pa_y     <= pa[1];
    s4_ent_r.pa_z     <= pa[2];
    s4_ent_r.pb_x     <= pb[0];
    s4_ent_r.pb_y     <= pb[1];
    s4_ent_r.pb_z     <= pb[2];
  end

  assign q_push = v4_r;
  assign q_data = s4_ent_r;

endmodule

// File: sv/pbe_queue.sv
// Small particle queue between the front pipeline and the corner emitter.
module pbe_queue #(
  parameter int unsigned DEPTH = pbe_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pbe_pkg::qent_t push_data,
  input  logic           pop,
  output logic           head_valid,
  output pbe_pkg::qent_t head_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pbe_pkg::qent_t   ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  // front credits guarantee no push into a full queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_data  = ent_r[rd_ptr_r];

endmodule

// File: sv/pbe_back.sv
// Corner emitter: four corners per queued particle into an output register.
module pbe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  pbe_pkg::qent_t  head_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output pbe_pkg::corner_t out_corner,
  output logic            out_last
);

  localparam int unsigned PUSH_W = pbe_pkg::PUSH_W;
  localparam int unsigned ACC_W  = pbe_pkg::ACC_W;

  logic [1:0]        k_r;
  logic              ov_r;
  logic              last_r;
  pbe_pkg::corner_t  corner_r;
  pbe_pkg::corner_t  corner_nxt;
  logic              load;

  // center*2^20 +- pa +- pb, rounded half up to Q16.16, saturated
  function automatic logic signed [31:0] corner_coord(
    input logic signed [31:0]       ctr,
    input logic signed [PUSH_W-1:0] pa,
    input logic signed [PUSH_W-1:0] pb,
    input logic                     cu,
    input logic                     cv
  );
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] pa_x;
    logic signed [ACC_W-1:0] pb_x;
    logic signed [32:0]      q;
    acc  = {ctr[31], ctr, 20'd0};
    pa_x = {{(ACC_W-PUSH_W){pa[PUSH_W-1]}}, pa};
    pb_x = {{(ACC_W-PUSH_W){pb[PUSH_W-1]}}, pb};
    acc  = acc + (cu ? pa_x : -pa_x) + (cv ? pb_x : -pb_x) + ACC_W'(524288);
    q    = acc[ACC_W-1:20];
    if (q[32] != q[31]) begin
      corner_coord = q[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      corner_coord = q[31:0];
    end
  endfunction

  assign load = head_valid && (!ov_r || out_ready);
  assign pop  = load && (k_r == 2'd3);

  always_comb begin
    corner_nxt.tex_u       = k_r[0];
    corner_nxt.tex_v       = k_r[1];
    corner_nxt.red         = head_data.color[7:0];
    corner_nxt.green       = head_data.color[15:8];
    corner_nxt.blue        = head_data.color[23:16];
    corner_nxt.alpha_level = head_data.color[31:24];
    corner_nxt.vert_x = corner_coord(head_data.center_x, head_data.pa_x, head_data.pb_x,
                                     k_r[0], k_r[1]);
    corner_nxt.vert_y = corner_coord(head_data.center_y, head_data.pa_y, head_data.pb_y,
                                     k_r[0], k_r[1]);
    corner_nxt.vert_z = corner_coord(head_data.center_z, head_data.pa_z, head_data.pb_z,
                                     k_r[0], k_r[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      if (load) begin
        k_r  <= k_r + 1'b1;
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      corner_r <= corner_nxt;
      last_r   <= (k_r == 2'd3);
    end
  end

  assign out_valid  = ov_r;
  assign out_corner = corner_r;
  assign out_last   = last_r;

endmodule
